// ===== sv/oprle_pkg.sv =====
package oprle_pkg;

   localparam int unsigned SLOT_COUNT  = 8;
   localparam int unsigned BLOCK_BYTES = 4;
   localparam logic [31:0] RUN_MAX     = 32'h7FFF_FFFF;

   // Coder modes; the unused code behaves as block start.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_RAW   = 2'd2;

   // One input byte's worth of coded output, first byte in the top slot.
   typedef struct packed {
      logic [3:0]                nbytes;
      logic                      is_final;
      logic [SLOT_COUNT*8-1:0]   bytes;
   } cmd_type;

endpackage

// ===== sv/oprle_if.sv =====
interface oprle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface oprle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] coded_byte;
   logic       coded_last;

   modport source (output valid, output coded_byte, output coded_last, input ready);
   modport sink   (input valid, input coded_byte, input coded_last, output ready);
endinterface

// ===== sv/oprle_front.sv =====
module oprle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                is_last,
   output logic                push,
   output oprle_pkg::cmd_type  cmd
);

   logic [7:0]  buf_ff [3];
   logic [1:0]  count_ff, count_in;
   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  raw_rem_ff, raw_rem_in;
   logic [7:0]  run_value_ff, run_value_in;
   logic [31:0] run_len_ff, run_len_in;

   logic [7:0]  slot [oprle_pkg::SLOT_COUNT];
   logic [31:0] run_len_inc;
   logic [31:0] code;
   logic        all_equal;
   logic [3:0]  nbytes;
   logic        is_final;

   assign run_len_inc = (run_len_ff < oprle_pkg::RUN_MAX) ? run_len_ff + 32'd1 : run_len_ff;
   assign all_equal   = (buf_ff[0] == buf_ff[1]) && (buf_ff[0] == buf_ff[2])
                        && (buf_ff[0] == data_byte);

   always_comb begin
      count_in     = count_ff;
      mode_in      = mode_ff;
      raw_rem_in   = raw_rem_ff;
      run_value_in = run_value_ff;
      run_len_in   = run_len_ff;
      nbytes       = 4'd0;
      is_final     = 1'b0;
      code         = run_len_ff;
      for (int i = 0; i < oprle_pkg::SLOT_COUNT; i++) begin
         slot[i] = data_byte;
      end
      case (mode_ff)
         oprle_pkg::MODE_RUN: begin
            if (data_byte == run_value_ff) begin
               run_len_in = run_len_inc;
               code       = run_len_inc;
               if (is_last) begin
                  nbytes   = 4'd4;
                  is_final = 1'b1;
                  mode_in  = oprle_pkg::MODE_START;
                  count_in = 2'd0;
               end
            end else begin
               // inverted count keeps byte order when the breaking byte is higher
               code    = (data_byte > run_value_ff) ? ~run_len_ff : run_len_ff;
               mode_in = oprle_pkg::MODE_START;
               if (is_last) begin
                  nbytes   = 4'd5;
                  is_final = 1'b1;
                  count_in = 2'd0;
               end else begin
                  nbytes   = 4'd4;
                  count_in = 2'd1;
               end
            end
            slot[0] = code[31:24];
            slot[1] = code[23:16];
            slot[2] = code[15:8];
            slot[3] = code[7:0];
         end
         oprle_pkg::MODE_RAW: begin
            nbytes   = 4'd1;
            is_final = is_last;
            if (raw_rem_ff == 3'd1 || raw_rem_ff == 3'd0 || is_last) begin
               raw_rem_in = 3'd0;
               mode_in    = oprle_pkg::MODE_START;
               count_in   = 2'd0;
            end else begin
               raw_rem_in = raw_rem_ff - 3'd1;
            end
         end
         default: begin
            mode_in = oprle_pkg::MODE_START;
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < count_ff) begin
                  slot[i] = buf_ff[i];
               end
            end
            if (count_ff != 2'd3) begin
               count_in = count_ff + 2'd1;
               if (is_last) begin
                  nbytes   = {2'b00, count_ff} + 4'd1;
                  is_final = 1'b1;
                  count_in = 2'd0;
               end
            end else begin
               count_in = 2'd0;
               nbytes   = 4'd4;
               if (all_equal) begin
                  if (is_last) begin
                     nbytes   = 4'd8;
                     is_final = 1'b1;
                     slot[4]  = 8'h00;
                     slot[5]  = 8'h00;
                     slot[6]  = 8'h00;
                     slot[7]  = 8'(oprle_pkg::BLOCK_BYTES);
                  end else begin
                     mode_in      = oprle_pkg::MODE_RUN;
                     run_value_in = data_byte;
                     run_len_in   = 32'(oprle_pkg::BLOCK_BYTES);
                  end
               end else begin
                  is_final = is_last;
                  if (!is_last) begin
                     mode_in    = oprle_pkg::MODE_RAW;
                     raw_rem_in = 3'(oprle_pkg::BLOCK_BYTES);
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      cmd.nbytes   = nbytes;
      cmd.is_final = is_final;
      for (int i = 0; i < oprle_pkg::SLOT_COUNT; i++) begin
         cmd.bytes[(oprle_pkg::SLOT_COUNT - 1 - i)*8 +: 8] = slot[i];
      end
   end

   assign push = accept && (nbytes != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         mode_ff      <= oprle_pkg::MODE_START;
         raw_rem_ff   <= 3'd0;
         run_value_ff <= 8'd0;
         run_len_ff   <= 32'd0;
      end else if (accept) begin
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         raw_rem_ff   <= raw_rem_in;
         run_value_ff <= run_value_in;
         run_len_ff   <= run_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mode_ff != oprle_pkg::MODE_RUN && mode_ff != oprle_pkg::MODE_RAW
          && count_ff != 2'd3) begin
         buf_ff[count_ff] <= data_byte;
      end else if (accept && mode_ff == oprle_pkg::MODE_RUN && data_byte != run_value_ff) begin
         buf_ff[0] <= data_byte;
      end
   end

endmodule

// ===== sv/oprle_queue.sv =====
module oprle_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  oprle_pkg::cmd_type  push_cmd,
   output logic                can_push,
   input  logic                pop,
   output logic                not_empty,
   output oprle_pkg::cmd_type  head_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   oprle_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign can_push  = (fill_ff != CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && can_push;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/oprle_back.sv =====
module oprle_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  oprle_pkg::cmd_type  q_cmd,
   output logic                pop,
   oprle_rsp_if.source         rsp
);

   localparam int unsigned WORK_W = oprle_pkg::SLOT_COUNT * 8;

   logic [WORK_W-1:0] work_ff, work_in;
   logic [3:0]        rem_ff, rem_in;
   logic              final_ff, final_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;
   logic              emit, load;

   assign emit = (rem_ff != 4'd0) && (!out_valid_ff || rsp.ready);
   // refill on the cycle the final byte leaves, so commands follow without a gap
   assign load = (rem_ff == 4'd0) || (emit && rem_ff == 4'd1);
   assign pop  = load && q_valid;

   always_comb begin
      work_in      = work_ff;
      rem_in       = rem_ff;
      final_in     = final_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (emit) begin
         out_valid_in = 1'b1;
         rem_in       = rem_ff - 4'd1;
         work_in      = {work_ff[WORK_W-9:0], 8'h00};
      end
      if (pop) begin
         work_in  = q_cmd.bytes;
         rem_in   = q_cmd.nbytes;
         final_in = q_cmd.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      final_ff <= final_in;
      if (emit) begin
         out_byte_ff <= work_ff[WORK_W-1 -: 8];
         out_last_ff <= (rem_ff == 4'd1) && final_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.coded_byte = out_byte_ff;
   assign rsp.coded_last = out_last_ff;

endmodule

// ===== sv/order_preserving_rle_compressor_top.sv =====
// Order-preserving run-length coder.
// req_if: one string byte per transfer, is_last on the final byte of a string.
// rsp_if: one coded byte per transfer, coded_last on the final coded byte.
// Each input byte yields zero to eight coded bytes. The front end classifies a
// byte in the cycle it is taken and writes the bytes it causes, as one entry,
// into a QUEUE_DEPTH-entry queue; the back end plays the entry out one byte
// per cycle through an output register while rsp_if.ready allows it.
// Path: with the queue and back end idle, the first coded byte of a transfer
// moves through the queue entry, the work register and the output register.
// Throughput: one input byte per cycle while the queue has room; the output
// side moves one byte per cycle while rsp_if.ready is high, so the long-term
// input rate is set by the coded bytes per input byte (none inside a run, one
// per raw byte, four or five when a run closes, up to eight at a block start).
// Reset: synchronous; the coder returns to block start with an empty buffer
// and the queue and output register are emptied.
// When rsp_if.ready is low the output byte holds, the queue fills and
// req_if.ready drops once it is full; nothing is lost.
module order_preserving_rle_compressor_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   oprle_req_if.sink   req_if,
   oprle_rsp_if.source rsp_if
);

   oprle_pkg::cmd_type front_cmd;
   oprle_pkg::cmd_type head_cmd;
   logic               q_push, q_can_push, q_pop, q_not_empty;
   logic               req_accept;

   assign req_if.ready = q_can_push;
   assign req_accept   = req_if.valid && q_can_push;

   oprle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_if.data_byte),
      .is_last   (req_if.is_last),
      .push      (q_push),
      .cmd       (front_cmd)
   );

   oprle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (front_cmd),
      .can_push  (q_can_push),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   oprle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_cmd   (head_cmd),
      .pop     (q_pop),
      .rsp     (rsp_if)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_can_push)
      else $error("queue written while full");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("queue read while empty");

   a_entry_sized: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (front_cmd.nbytes <= 4'd8))
      else $error("entry holds more than eight bytes");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("output valid straight after reset");

endmodule

// ===== tb/tb_order_preserving_rle_compressor_top.sv =====
`timescale 1ns / 1ps

module tb_order_preserving_rle_compressor_top;

   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned RANDOM_BYTES = 330;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] coded;
      logic       fin;
   } coded_item_type;

   // Tracks the coder state and holds the coded bytes still owed by the block.
   class rle_code_tracker_type;
      coded_item_type pending_codes[$];
      logic [7:0]  blk[4];
      int unsigned nbuf;
      logic [1:0]  mode;
      int unsigned raw_left;
      logic [7:0]  run_byte;
      logic [31:0] run_len;
      int unsigned mismatches;
      int unsigned bytes_in;
      int unsigned bytes_out;
      int unsigned strings;
      int unsigned runs;
      int unsigned raw_blocks;
      int unsigned inverted_counts;

      function new();
         nbuf = 0;
         mode = oprle_pkg::MODE_START;
         raw_left = 0;
         run_byte = '0;
         run_len = '0;
         mismatches = 0;
         bytes_in = 0;
         bytes_out = 0;
         strings = 0;
         runs = 0;
         raw_blocks = 0;
         inverted_counts = 0;
      endfunction

      function void owe(logic [7:0] b, logic l);
         coded_item_type it;
         it.coded = b;
         it.fin = l;
         pending_codes = {pending_codes, it};
      endfunction

      // Big-endian run count, inverted when the run is closed by a greater byte.
      function void owe_count(logic [31:0] len, bit high, logic l);
         logic [31:0] code;
         code = high ? (32'hFFFF_FFFF - len) : len;
         if (high) inverted_counts++;
         owe(code[31:24], 1'b0);
         owe(code[23:16], 1'b0);
         owe(code[15:8], 1'b0);
         owe(code[7:0], l);
      endfunction

      function void take_byte(logic [7:0] b, logic l);
         bytes_in++;
         if (l) strings++;
         case (mode)
            oprle_pkg::MODE_RUN: begin
               if (b == run_byte) begin
                  if (run_len < oprle_pkg::RUN_MAX) run_len++;
                  if (l) begin
                     owe_count(run_len, 1'b0, 1'b1);
                     mode = oprle_pkg::MODE_START;
                     nbuf = 0;
                  end
               end else begin
                  owe_count(run_len, b > run_byte, 1'b0);
                  mode = oprle_pkg::MODE_START;
                  if (l) begin
                     owe(b, 1'b1);
                     nbuf = 0;
                  end else begin
                     blk[0] = b;
                     nbuf = 1;
                  end
               end
            end
            oprle_pkg::MODE_RAW: begin
               owe(b, l);
               if (raw_left > 0) raw_left--;
               if (raw_left == 0 || l) begin
                  raw_left = 0;
                  mode = oprle_pkg::MODE_START;
                  nbuf = 0;
               end
            end
            default: begin
               mode = oprle_pkg::MODE_START;
               blk[nbuf] = b;
               nbuf++;
               if (nbuf < oprle_pkg::BLOCK_BYTES) begin
                  if (l) begin
                     for (int i = 0; i < nbuf; i++)
                        owe(blk[i], (i + 1 == nbuf));
                     nbuf = 0;
                  end
               end else begin
                  nbuf = 0;
                  if (blk[0] == blk[1] && blk[0] == blk[2] && blk[0] == blk[3]) begin
                     for (int i = 0; i < 4; i++) owe(blk[i], 1'b0);
                     runs++;
                     if (l) begin
                        owe_count(32'd4, 1'b0, 1'b1);
                     end else begin
                        mode = oprle_pkg::MODE_RUN;
                        run_byte = blk[0];
                        run_len = 32'd4;
                     end
                  end else begin
                     for (int i = 0; i < 4; i++) owe(blk[i], (i == 3) ? l : 1'b0);
                     raw_blocks++;
                     if (!l) begin
                        mode = oprle_pkg::MODE_RAW;
                        raw_left = 4;
                     end
                  end
               end
            end
         endcase
      endfunction

      function void check_coded(logic [7:0] b, logic l);
         coded_item_type want;
         bytes_out++;
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: coded byte %0d unexpected: got %02h last %0b",
                        $realtime, bytes_out, b, l);
         end else begin
            want = pending_codes.pop_front();
            if (want.coded !== b || want.fin !== l) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: coded byte %0d: expected %02h last %0b, got %02h last %0b",
                           $realtime, bytes_out, want.coded, want.fin, b, l);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   oprle_req_if req_ch();
   oprle_rsp_if rsp_ch();

   order_preserving_rle_compressor_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   rle_code_tracker_type sb = new();

   bit          req_steady;
   bit          rsp_steady;
   int unsigned ready_hold;
   int unsigned phase_cycles;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.is_last = 1'b0;
      rsp_ch.ready = 1'b0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      ready_hold = 0;
      phase_cycles = 0;
      idle_cycles = 0;
   end

   always #5 clock = ~clock;

   // Result side: random stalls, with calm stretches now and then.
   always @(posedge clock) begin
      phase_cycles++;
      if (phase_cycles >= 150) begin
         phase_cycles = 0;
         rsp_steady = ($urandom_range(0, 2) == 0);
      end
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_steady && $urandom_range(0, 99) < 30) begin
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_coded(rsp_ch.coded_byte, rsp_ch.coded_last);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("tb_order_preserving_rle_compressor_top: errors");
            $finish;
         end
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (req_steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l);
      int unsigned gap;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.is_last <= l;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.take_byte(b, l);
   endtask

   task automatic send_string(input logic [7:0] str[$]);
      for (int i = 0; i < str.size(); i++)
         send_byte(str[i], (i == str.size() - 1));
   endtask

   // Strings built from runs, raw stretches and near-runs of one to three bytes.
   task automatic send_random_string();
      logic [7:0]  str[$];
      int unsigned segs;
      int unsigned kind;
      int unsigned len;
      logic [7:0]  v;
      segs = $urandom_range(1, 5);
      for (int s = 0; s < segs; s++) begin
         kind = $urandom_range(0, 9);
         v = pick_byte();
         if (kind < 5) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40) : $urandom_range(4, 10);
            repeat (len) str = {str, v};
         end else if (kind < 8) begin
            len = $urandom_range(1, 9);
            repeat (len) str = {str, pick_byte()};
         end else begin
            len = $urandom_range(1, 3);
            repeat (len) str = {str, v};
            str = {str, 8'(v ^ (8'h01 << $urandom_range(0, 7)))};
         end
      end
      req_steady = ($urandom_range(0, 3) == 0);
      send_string(str);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_string('{8'h00});
      send_string('{8'hFF, 8'h00, 8'hFF});                       // raw tail of three
      send_string('{8'hAA, 8'hAA, 8'hAA, 8'hAA});                // run of four at the end
      send_string('{8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h20});  // greater last byte
      send_string('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});         // run closed by end
      send_string('{8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h7F});  // lesser byte, then tail
      send_string('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h02, 8'hFD});  // raw block cut by end

      while (sb.bytes_in < RANDOM_BYTES) send_random_string();

      req_ch.valid <= 1'b0;
      while (sb.pending_codes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d input bytes in %0d strings, %0d coded bytes checked",
               sb.bytes_in, sb.strings, sb.bytes_out);
      $display("runs %0d (inverted counts %0d), raw blocks %0d, mismatches %0d",
               sb.runs, sb.inverted_counts, sb.raw_blocks, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
         $display("tb_order_preserving_rle_compressor_top: clean");
      end else begin
         $display("tb_order_preserving_rle_compressor_top: errors");
      end
      $finish;
   end

endmodule
